[rtl/ugsi_pkg.sv]
// shared constants, types and register codes of the uniform grid spatial index
`default_nettype none
package ugsi_pkg;
    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int CELL_CAPACITY = 16;
    localparam int ID_WIDTH      = 16;

    localparam int CFG_W  = 13;
    localparam int CRD_W  = 16;
    localparam int Q_W    = CRD_W + 1;
    localparam int OID_W  = 16;
    localparam int ID_W   = (ID_WIDTH < OID_W) ? ID_WIDTH : OID_W;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NCELLS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int SLOT_W = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CELL_CAPACITY + 1);
    localparam int NSLOTS = NCELLS * CELL_CAPACITY;
    localparam int STORE_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

    typedef enum logic [1:0] {
        REG_AREA_WIDTH  = 2'd0,
        REG_AREA_HEIGHT = 2'd1,
        REG_CELL_SIZE   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] cs;
    } t_geom;

    typedef struct packed {
        logic             query;
        logic             hit;
        logic [ID_W-1:0]  id;
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
    } t_cmd;
endpackage
`default_nettype wire

[rtl/ugsi_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module ugsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/ugsi_front.sv]
// front end: takes items, divides coordinates by the cell size, clamps to the grid
`default_nettype none
module ugsi_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire ugsi_pkg::t_geom               i_geom,
    input  wire logic                          i_action,
    input  wire logic [15:0]                   i_object_id,
    input  wire logic signed [15:0]            i_box_x_min,
    input  wire logic signed [15:0]            i_box_y_min,
    input  wire logic signed [15:0]            i_box_x_max,
    input  wire logic signed [15:0]            i_box_y_max,
    input  wire logic signed [15:0]            i_query_x,
    input  wire logic signed [15:0]            i_query_y,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output ugsi_pkg::t_cmd                     o_cmd,
    output logic                               o_idle
);
    import ugsi_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_LOAD  = 4'b0010,
        F_DIV   = 4'b0100,
        F_PUSH  = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [2:0] r_op;
    logic [3:0] r_cnt;
    logic [CFG_W-1:0] r_rem;
    logic [CRD_W-1:0] r_dvd;
    logic r_neg;
    logic r_query;
    logic [ID_W-1:0] r_id;
    logic signed [CRD_W-1:0] r_crd [4];
    logic signed [Q_W-1:0] r_q [6];

    logic signed [CRD_W-1:0] sel;
    logic [CRD_W-1:0] num;
    logic [CFG_W:0] trial;
    logic fit;
    logic [2:0] last_op;
    logic signed [Q_W-1:0] cols, rows, c0, c1, rr0, rr1;

    assign last_op = r_query ? 3'd3 : 3'd5;

    always_comb begin
        sel = 16'sd0;
        case (r_op)
            3'd2:    sel = r_crd[0];
            3'd3:    sel = r_crd[1];
            3'd4:    sel = r_crd[2];
            3'd5:    sel = r_crd[3];
            default: sel = 16'sd0;
        endcase
    end

    always_comb begin
        if (r_op == 3'd0) begin
            num = CRD_W'(i_geom.width) + CRD_W'(i_geom.cs) - 16'd1;
        end else if (r_op == 3'd1) begin
            num = CRD_W'(i_geom.height) + CRD_W'(i_geom.cs) - 16'd1;
        end else begin
            num = sel[CRD_W-1] ? 16'(-sel) : 16'(sel);
        end
    end

    assign trial = {r_rem, r_dvd[CRD_W-1]};
    assign fit   = trial >= {1'b0, i_geom.cs};

    always_comb begin
        cols = (r_q[0] > Q_W'(MAX_COLS)) ? Q_W'(MAX_COLS) : r_q[0];
        rows = (r_q[1] > Q_W'(MAX_ROWS)) ? Q_W'(MAX_ROWS) : r_q[1];
        c0   = (r_q[2] < 0) ? '0 : r_q[2];
        rr0  = (r_q[3] < 0) ? '0 : r_q[3];
        c1   = (r_q[4] > cols - 1) ? Q_W'(cols - 1) : r_q[4];
        rr1  = (r_q[5] > rows - 1) ? Q_W'(rows - 1) : r_q[5];
        o_cmd.query = r_query;
        o_cmd.id    = r_id;
        if (r_query) begin
            o_cmd.hit = (r_q[2] >= 0) && (r_q[2] < cols) && (r_q[3] >= 0) && (r_q[3] < rows);
            o_cmd.c0  = COL_W'(r_q[2]);
            o_cmd.r0  = ROW_W'(r_q[3]);
            o_cmd.c1  = COL_W'(r_q[2]);
            o_cmd.r1  = ROW_W'(r_q[3]);
        end else begin
            o_cmd.hit = (c0 <= c1) && (rr0 <= rr1);
            o_cmd.c0  = COL_W'(c0);
            o_cmd.r0  = ROW_W'(rr0);
            o_cmd.c1  = COL_W'(c1);
            o_cmd.r1  = ROW_W'(rr1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_take) n_state = F_LOAD;
            F_LOAD: n_state = F_DIV;
            F_DIV: begin
                if (r_cnt == 4'd15 && r_op == last_op) begin
                    n_state = F_PUSH;
                end else if (r_cnt == 4'd15) begin
                    n_state = F_LOAD;
                end
            end
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_q_full;
    assign o_idle = (r_state == F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_op    <= 3'd0;
                r_query <= i_action;
                r_id    <= ID_W'(i_object_id);
                r_crd[0] <= i_action ? i_query_x : i_box_x_min;
                r_crd[1] <= i_action ? i_query_y : i_box_y_min;
                r_crd[2] <= i_box_x_max;
                r_crd[3] <= i_box_y_max;
            end
            F_LOAD: begin
                r_dvd <= num;
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= (r_op >= 3'd2) && sel[CRD_W-1];
            end
            F_DIV: begin
                r_rem <= fit ? CFG_W'(trial - {1'b0, i_geom.cs}) : CFG_W'(trial);
                r_dvd <= {r_dvd[CRD_W-2:0], fit};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_q[r_op] <= r_neg ? -Q_W'({r_dvd[CRD_W-2:0], fit})
                                       : Q_W'({r_dvd[CRD_W-2:0], fit});
                    r_op <= r_op + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/ugsi_queue.sv]
// two entry command queue between front and back
`default_nettype none
module ugsi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ugsi_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output ugsi_pkg::t_cmd      o_cmd,
    output logic                o_full,
    output logic                o_nonempty
);
    import ugsi_pkg::*;

    t_cmd r_slot [2];
    logic r_wp, r_rp;
    logic [1:0] r_used;

    assign o_cmd      = r_slot[r_rp];
    assign o_full     = r_used == 2'd2;
    assign o_nonempty = r_used != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_used <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_used <= r_used + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

[rtl/ugsi_back.sv]
// back end: cell count and id memories, add sweep over cells, query readout
`default_nettype none
module ugsi_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ugsi_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_result_valid,
    output logic [15:0]         o_found_id,
    output logic                o_cell_empty,
    output logic                o_overflow,
    output logic                o_last_result
);
    import ugsi_pkg::*;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_ARD  = 7'b0000100,
        S_AWR  = 7'b0001000,
        S_ADN  = 7'b0010000,
        S_QCNT = 7'b0100000,
        S_QID  = 7'b1000000
    } t_bstate;

    t_bstate r_state, n_state;
    t_cmd r_cmd;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [CELL_W-1:0] r_clr;
    logic r_ovf;
    logic [CNT_W-1:0] r_n, r_k;

    logic [CELL_W-1:0] cell_addr, pcell;
    logic [CNT_W-1:0] cnt_rd;
    logic cnt_we;
    logic [CELL_W-1:0] cnt_wa;
    logic [CNT_W-1:0] cnt_wd;
    logic id_we;
    logic [STORE_W-1:0] id_ra, id_wa;
    logic [ID_W-1:0] id_rd;
    logic full;
    logic [CNT_W-1:0] rd_slot;

    assign cell_addr = CELL_W'(r_row) * CELL_W'(MAX_COLS) + CELL_W'(r_col);
    assign pcell = CELL_W'(i_cmd.r0) * CELL_W'(MAX_COLS) + CELL_W'(i_cmd.c0);
    assign full  = cnt_rd >= CNT_W'(CELL_CAPACITY);

    assign cnt_we = (r_state == S_CLR) || ((r_state == S_AWR) && !full);
    assign cnt_wa = (r_state == S_CLR) ? r_clr : cell_addr;
    assign cnt_wd = (r_state == S_CLR) ? '0 : cnt_rd + CNT_W'(1);
    assign id_we  = (r_state == S_AWR) && !full;
    assign id_wa  = STORE_W'(cell_addr) * STORE_W'(CELL_CAPACITY) + STORE_W'(cnt_rd);
    assign rd_slot = (r_state == S_QID) ? r_k + CNT_W'(1) : '0;
    assign id_ra  = STORE_W'(cell_addr) * STORE_W'(CELL_CAPACITY) + STORE_W'(rd_slot);

    ugsi_ram #(.WIDTH(CNT_W), .DEPTH(NCELLS)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_wa),
        .i_wdata (cnt_wd),
        .i_raddr ((r_state == S_IDLE) ? pcell : cell_addr),
        .o_rdata (cnt_rd)
    );

    ugsi_ram #(.WIDTH(ID_W), .DEPTH(NSLOTS)) u_ids (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_wa),
        .i_wdata (r_cmd.id),
        .i_raddr (id_ra),
        .o_rdata (id_rd)
    );

    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_clearing = (r_state == S_CLR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == CELL_W'(NCELLS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.hit) begin
                        n_state = i_cmd.query ? S_IDLE : S_ADN;
                    end else begin
                        n_state = i_cmd.query ? S_QCNT : S_ARD;
                    end
                end
            end
            S_ARD:  n_state = S_AWR;
            S_AWR: begin
                if (r_col == r_cmd.c1 && r_row == r_cmd.r1) n_state = S_ADN;
                else n_state = S_ARD;
            end
            S_ADN:  n_state = S_IDLE;
            S_QCNT: if (cnt_rd == '0) n_state = S_IDLE; else n_state = S_QID;
            S_QID:  if (r_k + CNT_W'(1) == r_n) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_clr          <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_result_valid <= 1'b0;
            if (r_state == S_CLR) r_clr <= r_clr + CELL_W'(1);
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.query && !i_cmd.hit) o_result_valid <= 1'b1;
                end
                S_ADN:  o_result_valid <= 1'b1;
                S_QCNT: o_result_valid <= cnt_rd == '0;
                S_QID:  o_result_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_row <= i_cmd.r0;
                r_col <= i_cmd.c0;
                r_ovf <= 1'b0;
                o_found_id    <= '0;
                o_cell_empty  <= 1'b1;
                o_overflow    <= 1'b0;
                o_last_result <= 1'b1;
            end
            S_AWR: begin
                if (full) r_ovf <= 1'b1;
                if (r_col == r_cmd.c1) begin
                    r_col <= r_cmd.c0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            S_ADN: begin
                o_found_id    <= '0;
                o_cell_empty  <= 1'b0;
                o_overflow    <= r_ovf;
                o_last_result <= 1'b1;
            end
            S_QCNT: begin
                r_n <= cnt_rd;
                r_k <= '0;
                o_found_id    <= '0;
                o_cell_empty  <= 1'b1;
                o_overflow    <= 1'b0;
                o_last_result <= 1'b1;
            end
            S_QID: begin
                r_k <= r_k + CNT_W'(1);
                o_found_id    <= 16'(id_rd);
                o_cell_empty  <= 1'b0;
                o_overflow    <= 1'b0;
                o_last_result <= r_k + CNT_W'(1) == r_n;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/uniform_grid_spatial_index.sv]
// top level of the uniform grid spatial index
//
//  channel   direction  handshake                 payload
//  item      in         start high, busy low      action, object_id, box, query point
//  result    out        o_result_valid strobe     found_id, cell_empty, overflow, last_result
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// the front divides with a one bit per cycle divider, four divisions for a query and six for an
// add; the item is queued once the last division is done and the queue has room, and busy
// drops in the cycle after that; the back sweeps an add over its covered cells with a read and
// a write state per cell, and for a query reads the cell count and then its ids one by one
// after reset a clearing pass over all 4096 cells zeroes the cell counts, busy stays high meanwhile
// a two entry queue lets the front take the next item while the back works
// results cannot be stalled
`default_nettype none
module uniform_grid_spatial_index (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic [15:0]        i_object_id,
    input  wire logic signed [15:0] i_box_x_min,
    input  wire logic signed [15:0] i_box_y_min,
    input  wire logic signed [15:0] i_box_x_max,
    input  wire logic signed [15:0] i_box_y_max,
    input  wire logic signed [15:0] i_query_x,
    input  wire logic signed [15:0] i_query_y,
    output logic                    o_result_valid,
    output logic [15:0]             o_found_id,
    output logic                    o_cell_empty,
    output logic                    o_overflow,
    output logic                    o_last_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [12:0]        i_cfg_data
);
    import ugsi_pkg::*;

    logic [CFG_W-1:0] r_width, r_height, r_cs;
    t_geom geom;
    t_cmd f_cmd, q_cmd;
    logic take, push, pop, q_full, q_nonempty, f_idle, clearing;

    assign o_cfg_ready = 1'b1;
    assign busy        = !f_idle || clearing;
    assign take        = start && !busy;

    assign geom.width  = (r_width  == '0) ? CFG_W'(1) : r_width;
    assign geom.height = (r_height == '0) ? CFG_W'(1) : r_height;
    assign geom.cs     = (r_cs     == '0) ? CFG_W'(1) : r_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1024);
            r_height <= CFG_W'(1024);
            r_cs     <= CFG_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AREA_WIDTH:  r_width  <= i_cfg_data;
                REG_AREA_HEIGHT: r_height <= i_cfg_data;
                REG_CELL_SIZE:   r_cs     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ugsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_geom      (geom),
        .i_action    (i_action),
        .i_object_id (i_object_id),
        .i_box_x_min (i_box_x_min),
        .i_box_y_min (i_box_y_min),
        .i_box_x_max (i_box_x_max),
        .i_box_y_max (i_box_y_max),
        .i_query_x   (i_query_x),
        .i_query_y   (i_query_y),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_idle      (f_idle)
    );

    ugsi_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (f_cmd),
        .i_pop      (pop),
        .o_cmd      (q_cmd),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    ugsi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_cmd_valid    (q_nonempty),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_found_id     (o_found_id),
        .o_cell_empty   (o_cell_empty),
        .o_overflow     (o_overflow),
        .o_last_result  (o_last_result)
    );

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |=> !o_result_valid) else $error("result during clearing pass");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full) else $error("queue overrun");
    a_empty_has_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_cell_empty) |-> (o_found_id == 16'd0 && o_last_result))
        else $error("empty result carries an id");
    a_overflow_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_overflow) |-> (o_last_result && !o_cell_empty))
        else $error("overflow on a query result");
`endif
endmodule
`default_nettype wire
